[hw/rtl/sdmec_pkg.sv]
package sdmec_pkg;

	// field widths
	localparam int KEY_W   = 64;
	localparam int SCORE_W = 16;
	localparam int HALF_W  = 17;
	localparam int ENTRY_W = KEY_W + SCORE_W;

	// half size after reset
	localparam logic [HALF_W-1:0] HALF_RESET = 17'd65521;

	// command codes
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_PROBE = 2'd0;
	localparam cmd_t CMD_STORE = 2'd1;
	localparam cmd_t CMD_CLEAR = 2'd2;

	// request item
	typedef struct packed {
		cmd_t                      cmd;
		logic                      white_to_move;
		logic [KEY_W-1:0]          position_key;
		logic signed [SCORE_W-1:0] eval_score;
	} req_t;

	// response item
	typedef struct packed {
		logic                      found;
		logic signed [SCORE_W-1:0] cached_score;
	} rsp_t;

endpackage

[hw/rtl/split_direct_mapped_eval_cache.sv]
// channel | direction | handshake             | item
// req     | in        | req_valid / req_stall | sdmec_pkg::req_t
// rsp     | out       | rsp_valid / rsp_stall | sdmec_pkg::rsp_t
// cfg     | in        | cfg_we                | half_size (17 bits)
//
// probe and store run through the one-bit-per-cycle remainder unit (64 steps)
// plus one memory access; a probe's read data arrives in the cycle after the address
// clear sweeps the whole table, one table entry written per cycle
// after reset the same sweep runs over the whole table before req_stall drops
// a finished probe result waits in the rsp register; the next item may be taken meanwhile
module split_direct_mapped_eval_cache #(
	parameter int TABLE_DEPTH = 131072
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  sdmec_pkg::req_t                  req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output sdmec_pkg::rsp_t                  rsp,
	input  logic                             cfg_we,
	input  logic [sdmec_pkg::HALF_W-1:0]     cfg_data
);

	localparam int AW       = $clog2(TABLE_DEPTH);
	localparam int HALF_LIM = TABLE_DEPTH / 2;
	localparam int LIM_W    = $clog2(HALF_LIM + 1);
	localparam int EW       = LIM_W > sdmec_pkg::HALF_W ? LIM_W : sdmec_pkg::HALF_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_ACC,
		ST_LOOK
	} state_t;

	state_t                           state_q;
	logic [AW-1:0]                    clr_addr_q;
	logic [sdmec_pkg::HALF_W-1:0]     half_size_q;
	sdmec_pkg::cmd_t                  cmd_q;
	logic                             white_q;
	logic [sdmec_pkg::KEY_W-1:0]      key_q;
	logic [sdmec_pkg::SCORE_W-1:0]    score_q;
	logic                             rsp_valid_q;
	sdmec_pkg::rsp_t                  rsp_q;

	logic [EW-1:0]                    half_ext;
	logic [EW-1:0]                    eff_half;
	logic                             req_take;
	logic                             div_start;
	logic                             div_done;
	logic [EW-1:0]                    div_rem;
	logic [EW:0]                      slot_sum;
	logic [AW-1:0]                    slot;
	logic                             ram_we;
	logic                             ram_re;
	logic [AW-1:0]                    ram_addr;
	logic [sdmec_pkg::ENTRY_W-1:0]    ram_wdata;
	logic [sdmec_pkg::ENTRY_W-1:0]    ram_rdata;
	logic                             hit;
	logic                             rsp_free;

	// half size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_size_q <= sdmec_pkg::HALF_RESET;
		end else if (cfg_we) begin
			half_size_q <= cfg_data;
		end
	end

	// zero reads as one, oversize clamps to half the table
	always_comb begin
		half_ext = EW'(half_size_q);
		if (half_ext == '0) begin
			eff_half = EW'(1);
		end else if (half_ext > EW'(HALF_LIM)) begin
			eff_half = EW'(HALF_LIM);
		end else begin
			eff_half = half_ext;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign div_start = req_take && (req.cmd == sdmec_pkg::CMD_PROBE ||
		req.cmd == sdmec_pkg::CMD_STORE);

	// key modulo half size
	sdmec_mod #(
		.DW(EW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(req.position_key),
		.divisor (eff_half),
		.done    (div_done),
		.rem     (div_rem)
	);

	// black to move lands in the upper half
	assign slot_sum = {1'b0, div_rem} + (white_q ? '0 : {1'b0, eff_half});
	assign slot     = AW'(slot_sum);

	// memory port
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = slot;
		ram_wdata = {key_q, score_q};
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_addr  = clr_addr_q;
			ram_wdata = '0;
		end else if (state_q == ST_ACC) begin
			ram_we = (cmd_q == sdmec_pkg::CMD_STORE);
			ram_re = (cmd_q == sdmec_pkg::CMD_PROBE);
		end
	end

	sdmec_ram #(
		.WIDTH(sdmec_pkg::ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// tag compare on the returned entry
	assign hit      = (ram_rdata[sdmec_pkg::ENTRY_W-1:sdmec_pkg::SCORE_W] == key_q);
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// sequencer with result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a result leaves unless a new one is loaded in its place
			if (rsp_valid_q && !rsp_stall && state_q != ST_LOOK) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (clr_addr_q == AW'(TABLE_DEPTH - 1)) begin
						clr_addr_q <= '0;
						state_q    <= ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (req_take) begin
						if (req.cmd == sdmec_pkg::CMD_CLEAR) begin
							state_q <= ST_CLEAR;
						end else if (div_start) begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (cmd_q == sdmec_pkg::CMD_PROBE) begin
						state_q <= ST_LOOK;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_LOOK: begin
					if (rsp_free) begin
						rsp_valid_q        <= 1'b1;
						rsp_q.found        <= hit;
						rsp_q.cached_score <= hit ?
							$signed(ram_rdata[sdmec_pkg::SCORE_W-1:0]) : '0;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// captured request fields
	always_ff @(posedge clk) begin
		if (req_take) begin
			cmd_q   <= req.cmd;
			white_q <= req.white_to_move;
			key_q   <= req.position_key;
			score_q <= req.eval_score;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hw/rtl/sdmec_ram.sv]
module sdmec_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 131072
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

[hw/rtl/sdmec_mod.sv]
module sdmec_mod #(
	parameter int DW = 17
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sdmec_pkg::KEY_W-1:0]  dividend,
	input  logic [DW-1:0]                divisor,
	output logic                         done,
	output logic [DW-1:0]                rem
);

	localparam int CNT_W = $clog2(sdmec_pkg::KEY_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [sdmec_pkg::KEY_W-1:0] dvd_q;
	logic [DW-1:0]               dvs_q;
	logic [DW-1:0]               rem_q;
	logic [DW:0]                 trial;
	logic [DW-1:0]               rem_nxt;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, dvd_q[sdmec_pkg::KEY_W-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_nxt = DW'(trial - {1'b0, dvs_q});
		end else begin
			rem_nxt = trial[DW-1:0];
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q  <= cnt_q + 1'b1;
				done_q <= (cnt_q == CNT_W'(sdmec_pkg::KEY_W - 1));
				if (cnt_q == CNT_W'(sdmec_pkg::KEY_W - 1)) begin
					busy_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// operand and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[sdmec_pkg::KEY_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

[hw/rtl/sdmec_chk.sv]
module sdmec_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_stall,
	input sdmec_pkg::req_t req,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input sdmec_pkg::rsp_t rsp
);

	// a held result keeps its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp item changed while stalled");

	// probe and store occupy the block for the remainder steps
	a_busy_after_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && (req.cmd == sdmec_pkg::CMD_PROBE ||
		req.cmd == sdmec_pkg::CMD_STORE) |=> req_stall)
		else $error("req taken again straight after a probe or store");

	// clear sweeps the table before the next item
	a_busy_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.cmd == sdmec_pkg::CMD_CLEAR |=> req_stall)
		else $error("req taken straight after a clear");

	// a probe result cannot appear in the cycle after its request
	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
		else $error("rsp item raised too early");

	// a miss carries a zero score
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.cached_score == '0)
		else $error("miss with non-zero score");

endmodule

bind split_direct_mapped_eval_cache sdmec_chk u_sdmec_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
